// ===== design/assert_macros.svh =====
// assertion helpers used by the top-level design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication checked on every rising clock edge
`define BIA_ASSERT_SAME(lbl, clk, ante, cons, msg) \
   lbl: assert property (@(posedge clk) (ante) |-> (cons)) else $error(msg);

// next-cycle implication checked on every rising clock edge
`define BIA_ASSERT_NEXT(lbl, clk, ante, cons, msg) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/bia_pkg.sv =====
package bia_pkg;

   // operation codes of the input item
   localparam logic [4:0] OP_IADD  = 5'd0;
   localparam logic [4:0] OP_LADD  = 5'd1;
   localparam logic [4:0] OP_ISUB  = 5'd2;
   localparam logic [4:0] OP_LSUB  = 5'd3;
   localparam logic [4:0] OP_IMUL  = 5'd4;
   localparam logic [4:0] OP_LMUL  = 5'd5;
   localparam logic [4:0] OP_IDIV  = 5'd6;
   localparam logic [4:0] OP_LDIV  = 5'd7;
   localparam logic [4:0] OP_IREM  = 5'd8;
   localparam logic [4:0] OP_LREM  = 5'd9;
   localparam logic [4:0] OP_INEG  = 5'd10;
   localparam logic [4:0] OP_LNEG  = 5'd11;
   localparam logic [4:0] OP_ISHL  = 5'd12;
   localparam logic [4:0] OP_LSHL  = 5'd13;
   localparam logic [4:0] OP_ISHR  = 5'd14;
   localparam logic [4:0] OP_LSHR  = 5'd15;
   localparam logic [4:0] OP_IUSHR = 5'd16;
   localparam logic [4:0] OP_LUSHR = 5'd17;
   localparam logic [4:0] OP_IAND  = 5'd18;
   localparam logic [4:0] OP_LAND  = 5'd19;
   localparam logic [4:0] OP_IOR   = 5'd20;
   localparam logic [4:0] OP_LOR   = 5'd21;
   localparam logic [4:0] OP_IXOR  = 5'd22;
   localparam logic [4:0] OP_LXOR  = 5'd23;
   localparam logic [4:0] OP_IINC  = 5'd24;

   // shift count masks
   localparam logic [5:0] SHIFT_MASK_32 = 6'h1f;
   localparam logic [5:0] SHIFT_MASK_64 = 6'h3f;

   // one quotient bit per divider stage
   localparam int DIV_STEPS = 64;

   // default depth of the queue between front and back
   localparam int BIA_QUEUE_DEPTH = 2;

   // execution class of an item
   typedef enum logic [3:0] {
      CLS_NONE, CLS_ADD, CLS_SUB, CLS_MUL, CLS_DIV, CLS_REM, CLS_NEG,
      CLS_SHL, CLS_SHR, CLS_USHR, CLS_AND, CLS_OR, CLS_XOR
   } bia_cls_type;

   // classified item handed from front to back
   typedef struct packed {
      bia_cls_type cls;
      logic        narrow;
      logic        wl;
      logic [7:0]  widx;
      logic [5:0]  shamt;
      logic [63:0] a;
      logic [63:0] b;
   } bia_item_type;

   // payload of one back pipeline stage
   typedef struct packed {
      bia_cls_type cls;
      logic        narrow;
      logic        wl;
      logic [7:0]  widx;
      logic        dz;
      logic        neg_q;
      logic        neg_r;
      logic [63:0] res;
      logic [31:0] p1;
      logic [31:0] p2;
      logic [63:0] rem;
      logic [63:0] quo;
      logic [63:0] dvs;
   } bia_stage_type;

   function automatic logic [63:0] sext32(input logic [63:0] x);
      sext32 = {{32{x[31]}}, x[31:0]};
   endfunction

endpackage

// ===== design/bia_front.sv =====
module bia_front import bia_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  logic [4:0]   req_operation,
   input  logic [63:0]  req_value_a,
   input  logic [63:0]  req_value_b,
   input  logic [7:0]   req_local_index,
   input  logic         q_full,
   output logic         q_push,
   output bia_item_type q_item
);

   logic         vld_ff;
   logic         vld_in;
   bia_item_type item_ff;
   bia_item_type item_in;
   logic         load;

   // hand the held item to the queue when it has room
   assign q_push    = vld_ff && !q_full;
   assign req_stall = vld_ff && q_full;
   assign load      = req_valid && !req_stall;
   assign vld_in    = load || (vld_ff && q_full);
   assign q_item    = item_ff;

   // classify the operation and extend the operands
   always_comb begin
      item_in.cls    = CLS_NONE;
      item_in.narrow = !req_operation[0];
      item_in.wl     = 1'b0;
      item_in.widx   = 8'd0;
      item_in.a      = req_operation[0] ? req_value_a : sext32(req_value_a);
      item_in.b      = req_operation[0] ? req_value_b : sext32(req_value_b);
      item_in.shamt  = req_operation[0] ? (req_value_b[5:0] & SHIFT_MASK_64)
                                        : (req_value_b[5:0] & SHIFT_MASK_32);
      unique case (req_operation) inside
         OP_IADD, OP_LADD:   item_in.cls = CLS_ADD;
         OP_ISUB, OP_LSUB:   item_in.cls = CLS_SUB;
         OP_IMUL, OP_LMUL:   item_in.cls = CLS_MUL;
         OP_IDIV, OP_LDIV:   item_in.cls = CLS_DIV;
         OP_IREM, OP_LREM:   item_in.cls = CLS_REM;
         OP_INEG, OP_LNEG:   item_in.cls = CLS_NEG;
         OP_ISHL, OP_LSHL:   item_in.cls = CLS_SHL;
         OP_ISHR, OP_LSHR:   item_in.cls = CLS_SHR;
         OP_IUSHR, OP_LUSHR: begin
            item_in.cls = CLS_USHR;
            // logical shift sees the raw low word
            if (!req_operation[0]) begin
               item_in.a = {32'd0, req_value_a[31:0]};
            end
         end
         OP_IAND, OP_LAND:   item_in.cls = CLS_AND;
         OP_IOR, OP_LOR:     item_in.cls = CLS_OR;
         OP_IXOR, OP_LXOR:   item_in.cls = CLS_XOR;
         OP_IINC: begin
            item_in.cls    = CLS_ADD;
            item_in.narrow = 1'b1;
            item_in.wl     = 1'b1;
            item_in.widx   = req_local_index;
            item_in.b      = {{56{req_value_b[7]}}, req_value_b[7:0]};
         end
         default: begin
            item_in.cls    = CLS_NONE;
            item_in.narrow = 1'b0;
         end
      endcase
   end

   // holding register
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
      if (load) begin
         item_ff <= item_in;
      end
   end

endmodule

// ===== design/bia_fifo.sv =====
module bia_fifo import bia_pkg::*; #(
   parameter int DEPTH = BIA_QUEUE_DEPTH
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  bia_item_type push_item,
   output logic         full,
   input  logic         pop,
   output logic         not_empty,
   output bia_item_type pop_item
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   bia_item_type     mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff;
   logic [CNT_W-1:0] cnt_in;

   assign full      = (cnt_ff == CNT_W'(DEPTH));
   assign not_empty = (cnt_ff != '0);
   assign pop_item  = mem_ff[rd_ptr_ff];

   // pointer wrap and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   cnt_in = cnt_ff + 1'b1;
         2'b01:   cnt_in = cnt_ff - 1'b1;
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== design/bia_back.sv =====
module bia_back import bia_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         q_valid,
   input  bia_item_type q_item,
   output logic         q_pop,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output logic [63:0]  rsp_result,
   output logic         rsp_divide_by_zero,
   output logic         rsp_write_local,
   output logic [7:0]   rsp_write_index
);

   logic [DIV_STEPS:0] vld_ff;
   bia_stage_type      st_ff [DIV_STEPS+1];
   bia_stage_type      st_in [DIV_STEPS+1];
   logic               adv;

   logic               out_vld_ff;
   logic [63:0]        out_res_ff;
   logic [63:0]        out_res_in;
   logic               out_dz_ff;
   logic               out_wl_ff;
   logic [7:0]         out_widx_ff;

   logic [63:0]        pa;
   logic [63:0]        pb;
   logic [63:0]        p0;
   logic [31:0]        p1;
   logic [31:0]        p2;

   // whole pipeline moves while the output register can take an item
   assign adv   = !out_vld_ff || !rsp_stall;
   assign q_pop = adv && q_valid;

   // prep stage: simple results, partial products, divider setup
   always_comb begin
      pa = q_item.a;
      pb = q_item.b;
      p0 = pa[31:0] * pb[31:0];
      p1 = pa[31:0] * pb[63:32];
      p2 = pa[63:32] * pb[31:0];
      st_in[0].cls    = q_item.cls;
      st_in[0].narrow = q_item.narrow;
      st_in[0].wl     = q_item.wl;
      st_in[0].widx   = q_item.widx;
      st_in[0].dz     = (pb == 64'd0);
      st_in[0].neg_q  = pa[63] ^ pb[63];
      st_in[0].neg_r  = pa[63];
      st_in[0].p1     = p1;
      st_in[0].p2     = p2;
      st_in[0].rem    = 64'd0;
      st_in[0].quo    = pa[63] ? 64'd0 - pa : pa;
      st_in[0].dvs    = pb[63] ? 64'd0 - pb : pb;
      case (q_item.cls)
         CLS_ADD:  st_in[0].res = pa + pb;
         CLS_SUB:  st_in[0].res = pa - pb;
         CLS_MUL:  st_in[0].res = p0;
         CLS_NEG:  st_in[0].res = 64'd0 - pa;
         CLS_SHL:  st_in[0].res = pa << q_item.shamt;
         CLS_SHR:  st_in[0].res = 64'($signed(pa) >>> q_item.shamt);
         CLS_USHR: st_in[0].res = pa >> q_item.shamt;
         CLS_AND:  st_in[0].res = pa & pb;
         CLS_OR:   st_in[0].res = pa | pb;
         CLS_XOR:  st_in[0].res = pa ^ pb;
         default:  st_in[0].res = 64'd0;
      endcase
   end

   // one restoring divide step per stage, other items ride along
   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
      logic [63:0] shifted;
      logic        ge;
      always_comb begin
         st_in[k+1] = st_ff[k];
         shifted    = {st_ff[k].rem[62:0], st_ff[k].quo[63]};
         ge         = (shifted >= st_ff[k].dvs);
         st_in[k+1].rem = ge ? shifted - st_ff[k].dvs : shifted;
         st_in[k+1].quo = {st_ff[k].quo[62:0], ge};
         // first step also folds the cross products into the product
         if (k == 0 && st_ff[k].cls == CLS_MUL) begin
            st_in[k+1].res = st_ff[k].res + {st_ff[k].p1 + st_ff[k].p2, 32'd0};
         end
      end
   end

   // sign fixup of quotient or remainder, narrow forms sign-extended
   always_comb begin
      case (st_ff[DIV_STEPS].cls)
         CLS_DIV: out_res_in = st_ff[DIV_STEPS].dz ? 64'd0 :
                     (st_ff[DIV_STEPS].neg_q ? 64'd0 - st_ff[DIV_STEPS].quo
                                             : st_ff[DIV_STEPS].quo);
         CLS_REM: out_res_in = st_ff[DIV_STEPS].dz ? 64'd0 :
                     (st_ff[DIV_STEPS].neg_r ? 64'd0 - st_ff[DIV_STEPS].rem
                                             : st_ff[DIV_STEPS].rem);
         default: out_res_in = st_ff[DIV_STEPS].res;
      endcase
      if (st_ff[DIV_STEPS].narrow) begin
         out_res_in = sext32(out_res_in);
      end
   end

   // pipeline and output registers
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         vld_ff     <= {vld_ff[DIV_STEPS-1:0], q_valid};
         out_vld_ff <= vld_ff[DIV_STEPS];
      end
      if (adv) begin
         for (int i = 0; i <= DIV_STEPS; i++) begin
            st_ff[i] <= st_in[i];
         end
         out_res_ff  <= out_res_in;
         out_dz_ff   <= st_ff[DIV_STEPS].dz &&
                        (st_ff[DIV_STEPS].cls == CLS_DIV ||
                         st_ff[DIV_STEPS].cls == CLS_REM);
         out_wl_ff   <= st_ff[DIV_STEPS].wl;
         out_widx_ff <= st_ff[DIV_STEPS].widx;
      end
   end

   assign rsp_valid          = out_vld_ff;
   assign rsp_result         = out_res_ff;
   assign rsp_divide_by_zero = out_dz_ff;
   assign rsp_write_local    = out_wl_ff;
   assign rsp_write_index    = out_widx_ff;

endmodule

// ===== design/bytecode_integer_alu_top.sv =====
// items pass the front register, the queue, prep, divide and output stages
// throughput: one item per cycle, the 64-stage bit-per-stage divider pipeline
// and the three-way split 64-bit multiplier both take a new item every cycle
// a stalled result holds the whole back pipeline; the front queue absorbs input
// reset: synchronous, active high, clears all valid bits and queue pointers
`include "assert_macros.svh"

module bytecode_integer_alu_top import bia_pkg::*; #(
   parameter int QUEUE_DEPTH = BIA_QUEUE_DEPTH
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  logic [4:0]   req_operation,
   input  logic [63:0]  req_value_a,
   input  logic [63:0]  req_value_b,
   input  logic [7:0]   req_local_index,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output logic [63:0]  rsp_result,
   output logic         rsp_divide_by_zero,
   output logic         rsp_write_local,
   output logic [7:0]   rsp_write_index
);

   logic         q_full;
   logic         q_push;
   bia_item_type q_push_item;
   logic         q_pop;
   logic         q_not_empty;
   bia_item_type q_pop_item;

   // accept and classify
   bia_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_operation   (req_operation),
      .req_value_a     (req_value_a),
      .req_value_b     (req_value_b),
      .req_local_index (req_local_index),
      .q_full          (q_full),
      .q_push          (q_push),
      .q_item          (q_push_item)
   );

   // decoupling queue
   bia_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_push_item),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .pop_item  (q_pop_item)
   );

   // execute
   bia_back u_back (
      .clock              (clock),
      .reset              (reset),
      .q_valid            (q_not_empty),
      .q_item             (q_pop_item),
      .q_pop              (q_pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_result         (rsp_result),
      .rsp_divide_by_zero (rsp_divide_by_zero),
      .rsp_write_local    (rsp_write_local),
      .rsp_write_index    (rsp_write_index)
   );

   // checks
   `BIA_ASSERT_NEXT(a_reset_clears, clock, reset, !rsp_valid && !req_stall, "reset left an item live")
   `BIA_ASSERT_SAME(a_dz_zero, clock, !reset && rsp_valid && rsp_divide_by_zero, rsp_result == 64'd0, "zero divisor gave nonzero result")
   `BIA_ASSERT_SAME(a_dz_stack, clock, !reset && rsp_valid && rsp_divide_by_zero, !rsp_write_local, "division item marked as local write")
   `BIA_ASSERT_SAME(a_idx_stack, clock, !reset && rsp_valid && !rsp_write_local, rsp_write_index == 8'd0, "stack result carries a slot index")

endmodule

// ===== tb/tb.sv =====
module tb import bia_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [4:0]  op;
      logic [63:0] a;
      logic [63:0] b;
      logic [7:0]  idx;
   } alu_item_type;

   typedef struct {
      logic [63:0] res;
      logic        dz;
      logic        wl;
      logic [7:0]  widx;
   } alu_result_type;

   localparam int STALL_LIMIT = 20000;
   localparam int N_RANDOM = 1130;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [4:0]  req_operation;
   logic [63:0] req_value_a;
   logic [63:0] req_value_b;
   logic [7:0]  req_local_index;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [63:0] rsp_result;
   logic        rsp_divide_by_zero;
   logic        rsp_write_local;
   logic [7:0]  rsp_write_index;

   alu_item_type   pending_items[$];
   alu_result_type expected_results[$];
   int          mismatch_count = 0;
   int          items_sent = 0;
   int          results_seen = 0;
   int          idle_cycles = 0;
   bit          stimulus_loaded = 0;
   bit          calm_phase = 0;
   bit          hold_rsp = 0;

   bytecode_integer_alu_top u_dut (.*);

   // clock
   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   function automatic logic [63:0] sx32(logic [63:0] x);
      return {{32{x[31]}}, x[31:0]};
   endfunction

   // signed truncating division on bit patterns, divisor nonzero
   function automatic void div_trunc(logic [63:0] a, logic [63:0] b,
                                     output logic [63:0] q, output logic [63:0] r);
      logic [63:0] ua, ub, mq, mr;
      ua = a[63] ? -a : a;
      ub = b[63] ? -b : b;
      mq = ua / ub;
      mr = ua % ub;
      q = (a[63] != b[63]) ? -mq : mq;
      r = a[63] ? -mr : mr;
   endfunction

   // expected result of one bytecode
   function automatic alu_result_type execute_bytecode(alu_item_type it);
      alu_result_type o;
      logic        narrow;
      logic [63:0] ax, bx, q, r;
      logic [4:0]  s32;
      logic [5:0]  s64;
      narrow = !it.op[0];
      ax = narrow ? sx32(it.a) : it.a;
      bx = narrow ? sx32(it.b) : it.b;
      s32 = it.b[4:0];
      s64 = it.b[5:0];
      o = '{64'd0, 1'b0, 1'b0, 8'd0};
      case (it.op) inside
         OP_IADD, OP_LADD: o.res = ax + bx;
         OP_ISUB, OP_LSUB: o.res = ax - bx;
         OP_IMUL, OP_LMUL: o.res = ax * bx;
         OP_IDIV, OP_LDIV, OP_IREM, OP_LREM: begin
            if (bx == 0) begin
               o.dz = 1'b1;
            end else begin
               div_trunc(ax, bx, q, r);
               o.res = (it.op < OP_IREM) ? q : r;
            end
         end
         OP_INEG, OP_LNEG: o.res = -ax;
         OP_ISHL:  o.res = ax << s32;
         OP_LSHL:  o.res = it.a << s64;
         OP_ISHR:  o.res = $signed(ax) >>> s32;
         OP_LSHR:  o.res = $signed(it.a) >>> s64;
         OP_IUSHR: o.res = {32'd0, it.a[31:0]} >> s32;
         OP_LUSHR: o.res = it.a >> s64;
         OP_IAND, OP_LAND: o.res = ax & bx;
         OP_IOR, OP_LOR:   o.res = ax | bx;
         OP_IXOR, OP_LXOR: o.res = ax ^ bx;
         OP_IINC: begin
            o.res = {32'd0, it.a[31:0]} + {{56{it.b[7]}}, it.b[7:0]};
            o.wl = 1'b1;
            o.widx = it.idx;
         end
         default: o.res = 0;
      endcase
      if (it.op <= OP_IINC && (narrow || it.op == OP_IINC)) o.res = sx32(o.res);
      return o;
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %h expected %h (result %0d)", what, got, want,
               results_seen);
      mismatch_count++;
   endtask

   function automatic logic [63:0] rand64();
      case ($urandom_range(0, 7))
         0: return 64'h8000_0000_0000_0000;
         1: return 64'h7fff_ffff_ffff_ffff;
         2: return {{32{1'b1}}, 32'h8000_0000};
         3: return {$urandom, 32'h8000_0000};
         4: return 64'($signed($urandom_range(0, 20)) - 10);
         default: return {$urandom, $urandom};
      endcase
   endfunction

   task automatic add_item(logic [4:0] op, logic [63:0] a, logic [63:0] b,
                           logic [7:0] idx);
      pending_items.push_back('{op, a, b, idx});
   endtask

   // stimulus
   initial begin
      logic [4:0]  op;
      logic [63:0] b;
      // directed: extremes, every operation, special cases
      add_item(OP_IDIV, 64'h0000_0000_8000_0000, 64'hffff_ffff_ffff_ffff, 8'd0);
      add_item(OP_LDIV, 64'h8000_0000_0000_0000, 64'hffff_ffff_ffff_ffff, 8'd0);
      add_item(OP_IREM, 64'h1234_5678_8000_0000, 64'h0000_0000_ffff_ffff, 8'd0);
      add_item(OP_LREM, 64'h8000_0000_0000_0000, 64'hffff_ffff_ffff_ffff, 8'd0);
      add_item(OP_IDIV, 64'd7, 64'hffff_ffff_0000_0000, 8'd0);
      add_item(OP_LREM, -64'sd7, 64'd0, 8'd0);
      add_item(OP_LDIV, -64'sd7, 64'd2, 8'd0);
      add_item(OP_IREM, 64'd7, -64'sd2, 8'd0);
      add_item(OP_INEG, 64'h0000_0000_8000_0000, 64'hdead, 8'd0);
      add_item(OP_LNEG, 64'h8000_0000_0000_0000, 64'd5, 8'd0);
      add_item(OP_ISHL, 64'h1, 64'hffff_ffff_ffff_ffe3, 8'd0);
      add_item(OP_LSHR, 64'h8000_0000_0000_0000, 64'h7f, 8'd0);
      add_item(OP_IUSHR, 64'hffff_ffff_ffff_ffff, 64'h21, 8'd0);
      add_item(OP_IINC, 64'hffff_ffff_7fff_ffff, 64'h1, 8'hff);
      add_item(OP_IINC, 64'h0000_0000_8000_0000, 64'h1234_5680, 8'h00);
      add_item(OP_LADD, 64'h7fff_ffff_ffff_ffff, 64'h1, 8'h55);
      add_item(OP_IMUL, 64'h7fff_ffff, 64'h7fff_ffff, 8'haa);
      add_item(OP_LMUL, 64'h8000_0000_0000_0000, 64'hffff_ffff_ffff_ffff, 8'd0);
      add_item(5'd31, 64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff, 8'hff);
      for (int k = 0; k <= OP_IINC; k++)
         add_item(5'(k), rand64(), rand64(), 8'($urandom));
      // random: mostly valid operations, some unused codes and zero divisors
      for (int n = 0; n < N_RANDOM; n++) begin
         op = ($urandom_range(0, 19) == 0) ? 5'($urandom_range(25, 31))
                                            : 5'($urandom_range(0, 24));
         b = rand64();
         if (op inside {[OP_IDIV:OP_LREM]} && $urandom_range(0, 9) == 0)
            b = $urandom_range(0, 1) ? 64'd0 : {$urandom, 32'd0};
         add_item(op, rand64(), b, 8'($urandom));
      end
      stimulus_loaded = 1;
   end

   // long receiver hold-off early in the run
   initial begin
      hold_rsp = 0;
      wait (items_sent >= 100);
      hold_rsp = 1;
      repeat (300) @(posedge clock);
      hold_rsp = 0;
   end

   // reset
   initial begin
      reset = 1;
      repeat (2) @(posedge clock);
      reset <= 0;
   end

   // driver
   int send_gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 0;
         req_operation <= 0;
         req_value_a <= 0;
         req_value_b <= 0;
         req_local_index <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_results.push_back(execute_bytecode('{req_operation, req_value_a,
                                                          req_value_b, req_local_index}));
            items_sent++;
         end
         if (!req_valid || !req_stall) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 0;
            end else if (stimulus_loaded && pending_items.size() > 0) begin
               alu_item_type it;
               it = pending_items.pop_front();
               req_valid <= 1;
               req_operation <= it.op;
               req_value_a <= it.a;
               req_value_b <= it.b;
               req_local_index <= it.idx;
               if (!calm_phase && $urandom_range(0, 15) == 0)
                  send_gap = $urandom_range(1, 18);
            end else begin
               req_valid <= 0;
            end
         end
      end
   end

   // monitor and receiver stall
   int recv_gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            alu_result_type w;
            if (expected_results.size() == 0) begin
               report_mismatch("unexpected result", rsp_result, 64'd0);
            end else begin
               w = expected_results.pop_front();
               if (rsp_result !== w.res) report_mismatch("result", rsp_result, w.res);
               if (rsp_divide_by_zero !== w.dz)
                  report_mismatch("divide_by_zero", rsp_divide_by_zero, w.dz);
               if (rsp_write_local !== w.wl)
                  report_mismatch("write_local", rsp_write_local, w.wl);
               if (rsp_write_index !== w.widx)
                  report_mismatch("write_index", rsp_write_index, w.widx);
            end
            results_seen++;
         end
         if (recv_gap > 0) begin
            recv_gap--;
            rsp_stall <= 1;
         end else if (hold_rsp) begin
            rsp_stall <= 1;
         end else if (!calm_phase && $urandom_range(0, 15) == 0) begin
            recv_gap = $urandom_range(0, 17);
            rsp_stall <= 1;
         end else begin
            rsp_stall <= 0;
         end
      end
   end

   // idling stops for the last part of the run
   always @(posedge clock)
      if (stimulus_loaded && pending_items.size() < 150) calm_phase <= 1;

   // watchdog
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("bytecode_integer_alu_top test failed");
         $finish;
      end
   end

   // end of run
   initial begin
      wait (stimulus_loaded);
      wait (pending_items.size() == 0 && !req_valid);
      wait (expected_results.size() == 0);
      repeat (100) @(posedge clock);
      $display("ran %0d bytecodes of all integer forms, iinc and unused codes;", items_sent);
      $display("%0d results checked, %0d mismatches", results_seen, mismatch_count);
      if (mismatch_count == 0 && expected_results.size() == 0)
         $display("bytecode_integer_alu_top test passed");
      else
         $display("bytecode_integer_alu_top test failed");
      $finish;
   end
endmodule
